// ===== rtl/mandelbrot_escape_pixel_defines.svh =====
// ----------------------------------------------------------------------------
// Mandelbrot escape pixel: assertion macros
// Shared property shorthands for the checker; clock and reset are taken
// from the scope of the module that uses them (clk, rst_n).
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_PIXEL_DEFINES_SVH

// Same-cycle implication
`define MEP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mandelbrot_escape_pixel: same-cycle check failed");

// Next-cycle implication
`define MEP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mandelbrot_escape_pixel: next-cycle check failed");

`endif

// ===== rtl/mep_pkg.sv =====
// ----------------------------------------------------------------------------
// mep_pkg
// Widths, register indexes, reset values and saturation helper for the
// Mandelbrot escape pixel evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package mep_pkg;

    // Field widths
    localparam int COORD_W = 10;
    localparam int FIX_W   = 32;   // Q4.28
    localparam int STEP_W  = 29;
    localparam int ITER_W  = 16;
    localparam int ESC_W   = 31;
    localparam int SHADE_W = 8;
    localparam int PROD_W  = 2 * FIX_W;
    localparam int SAT_W   = 42;   // widest sum that gets saturated

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IMAG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_LIMIT = 3'd5;

    // Reset values
    localparam logic signed [FIX_W-1:0] ORIGIN_REAL_RST  = -32'sd671088640; // -2.5
    localparam logic signed [FIX_W-1:0] ORIGIN_IMAG_RST  = -32'sd536870912; // -2.0
    localparam logic [STEP_W-1:0]       STEP_X_RST       = 29'd1342177;
    localparam logic [STEP_W-1:0]       STEP_Y_RST       = 29'd1342177;
    localparam logic [ITER_W-1:0]       ITER_LIMIT_RST   = 16'd200;
    localparam logic [ESC_W-1:0]        ESCAPE_LIMIT_RST = 31'd1073741824; // 4.0

    // Shades
    localparam logic [SHADE_W-1:0] SHADE_INTERIOR = 8'd0;
    localparam logic [SHADE_W-1:0] SHADE_EXTERIOR = 8'd255;

    // Clamp a wide signed value to the 32-bit signed range
    function automatic logic signed [FIX_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = {{(SAT_W-FIX_W+1){1'b0}}, {(FIX_W-1){1'b1}}};
        lo = {{(SAT_W-FIX_W+1){1'b1}}, {(FIX_W-1){1'b0}}};
        if (v > hi)
            sat32 = {1'b0, {(FIX_W-1){1'b1}}};
        else if (v < lo)
            sat32 = {1'b1, {(FIX_W-1){1'b0}}};
        else
            sat32 = v[FIX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mep_mult.sv =====
// ----------------------------------------------------------------------------
// mep_mult
// Shared 32x32 signed multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module mep_mult
    import mep_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [FIX_W-1:0]  a,
    input  wire logic signed [FIX_W-1:0]  b,
    output      logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // Product, held when not enabled
    assign prod_next = en ? (a * b) : prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_escape_pixel.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel
// Escape-time evaluator for one pixel: maps column/row to c in Q4.28,
// iterates z = z^2 + c on one shared multiplier and reports the count.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  in        request    in_valid / in_ready    column_index, row_index
//  out       result     out_valid / out_ready  out_column, out_row, interior,
//                                              iterations, shade
//  cfg       write      cfg_write_en           cfg_index, cfg_data
//
//  in_ready rises together with out_valid, when the result is handed over.
//  Each orbit step runs through the escape test, three multiplier uses
//  (zr*zi, zr^2, zi^2) and a capture of the last product; c is formed in MCR, MCI and CIS.
//  One pixel at a time; in_ready is high while the sequencer is idle.
//  A result not yet taken holds the sequencer in its last state.
//  Reset is asynchronous, active low; it loads the default configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_pixel
    import mep_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // pixel requests
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic [COORD_W-1:0]    column_index,
    input  wire logic [COORD_W-1:0]    row_index,
    // results
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic [COORD_W-1:0]    out_column,
    output      logic [COORD_W-1:0]    out_row,
    output      logic                  interior,
    output      logic [ITER_W-1:0]     iterations,
    output      logic [SHADE_W-1:0]    shade,
    // configuration
    input  wire logic                  cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [FIX_W-1:0]      cfg_data
);

    // Sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
    localparam logic [ST_W-1:0] ST_MCR  = 4'd1;  // column * step_x
    localparam logic [ST_W-1:0] ST_MCI  = 4'd2;  // row * step_y, form cr
    localparam logic [ST_W-1:0] ST_CIS  = 4'd3;  // form ci, snap, clear z
    localparam logic [ST_W-1:0] ST_TEST = 4'd4;  // escape / limit test
    localparam logic [ST_W-1:0] ST_MXY  = 4'd5;  // zr*zi, update zr
    localparam logic [ST_W-1:0] ST_MRR  = 4'd6;  // zr^2, update zi
    localparam logic [ST_W-1:0] ST_MII  = 4'd7;  // zi^2, store zr^2
    localparam logic [ST_W-1:0] ST_WII  = 4'd8;  // store zi^2
    localparam logic [ST_W-1:0] ST_DONE = 4'd9;  // hand over result

    // Configuration registers
    logic signed [FIX_W-1:0] origin_real_reg;
    logic signed [FIX_W-1:0] origin_imag_reg;
    logic [STEP_W-1:0]       step_x_reg;
    logic [STEP_W-1:0]       step_y_reg;
    logic [ITER_W-1:0]       iter_limit_reg;
    logic [ESC_W-1:0]        esc_limit_reg;

    // Control
    logic [ST_W-1:0] state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    // Datapath
    logic [COORD_W-1:0]      col_reg, col_next;
    logic [COORD_W-1:0]      row_reg, row_next;
    logic signed [FIX_W-1:0] cr_reg, cr_next;
    logic signed [FIX_W-1:0] ci_reg, ci_next;
    logic signed [FIX_W-1:0] zr_reg, zr_next;
    logic signed [FIX_W-1:0] zi_reg, zi_next;
    logic [PROD_W-2:0]       zr2_reg, zr2_next;
    logic [PROD_W-2:0]       zi2_reg, zi2_next;
    logic [ITER_W-1:0]       it_reg, it_next;

    // Result register
    logic [COORD_W-1:0] res_col_reg, res_col_next;
    logic [COORD_W-1:0] res_row_reg, res_row_next;
    logic               res_int_reg, res_int_next;
    logic [ITER_W-1:0]  res_it_reg, res_it_next;

    // Shared multiplier
    logic                     mul_en;
    logic signed [FIX_W-1:0]  mul_a;
    logic signed [FIX_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;

    mep_mult u_mult (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Operand selection per step
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = zr_reg;
        mul_b  = zi_reg;
        case (state_reg)
            ST_MCR:
            begin
                mul_a = $signed({{(FIX_W-COORD_W){1'b0}}, col_reg});
                mul_b = $signed({{(FIX_W-STEP_W){1'b0}}, step_x_reg});
            end
            ST_MCI:
            begin
                mul_a = $signed({{(FIX_W-COORD_W){1'b0}}, row_reg});
                mul_b = $signed({{(FIX_W-STEP_W){1'b0}}, step_y_reg});
            end
            ST_MXY:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
            ST_MRR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            ST_MII:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // c from origin plus scaled index (product is below 2^39)
    logic signed [SAT_W-1:0] cr_sum;
    logic signed [SAT_W-1:0] ci_sum;
    logic signed [FIX_W-1:0] ci_sat;
    logic [FIX_W-1:0]        ci_mag;
    logic                    ci_snap;

    assign cr_sum = $signed({{(SAT_W-FIX_W){origin_real_reg[FIX_W-1]}}, origin_real_reg})
                  + $signed({1'b0, prod[SAT_W-2:0]});
    assign ci_sum = $signed({{(SAT_W-FIX_W){origin_imag_reg[FIX_W-1]}}, origin_imag_reg})
                  + $signed({1'b0, prod[SAT_W-2:0]});
    assign ci_sat = sat32(ci_sum);
    assign ci_mag = ci_sat[FIX_W-1] ? (~ci_sat + 1'b1) : ci_sat;
    // snap when 2*|ci| < step_y
    assign ci_snap = ({ci_mag, 1'b0} < {{(FIX_W+1-STEP_W){1'b0}}, step_y_reg});

    // Orbit update: zi from zr*zi >> 27, zr from (zr^2 - zi^2) >> 28
    logic signed [PROD_W-1:0] sq_diff;
    logic signed [SAT_W-1:0]  zi_sum;
    logic signed [SAT_W-1:0]  zr_sum;

    assign sq_diff = $signed({1'b0, zr2_reg}) - $signed({1'b0, zi2_reg});
    assign zi_sum  = $signed({{(SAT_W-(PROD_W-27)){prod[PROD_W-1]}}, prod[PROD_W-1:27]})
                   + $signed({{(SAT_W-FIX_W){ci_reg[FIX_W-1]}}, ci_reg});
    assign zr_sum  = $signed({{(SAT_W-(PROD_W-28)){sq_diff[PROD_W-1]}},
                              sq_diff[PROD_W-1:28]})
                   + $signed({{(SAT_W-FIX_W){cr_reg[FIX_W-1]}}, cr_reg});

    // Escape test: |z|^2 against limit << 28, and the iteration count against its limit
    logic [PROD_W-1:0] sq_sum;
    logic [PROD_W-1:0] esc_wide;
    logic              keep_going;

    assign sq_sum     = {1'b0, zr2_reg} + {1'b0, zi2_reg};
    assign esc_wide   = {{(PROD_W-ESC_W-28){1'b0}}, esc_limit_reg, 28'd0};
    assign keep_going = (it_reg < iter_limit_reg) && (sq_sum < esc_wide);

    // Handshakes
    logic in_fire;
    logic out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        col_next       = col_reg;
        row_next       = row_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        zr2_next       = zr2_reg;
        zi2_next       = zi2_reg;
        it_next        = it_reg;
        res_col_next   = res_col_reg;
        res_row_next   = res_row_reg;
        res_int_next   = res_int_reg;
        res_it_next    = res_it_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    col_next   = column_index;
                    row_next   = row_index;
                    state_next = ST_MCR;
                end
            end
            ST_MCR:
            begin
                state_next = ST_MCI;
            end
            ST_MCI:
            begin
                cr_next    = sat32(cr_sum);
                state_next = ST_CIS;
            end
            ST_CIS:
            begin
                ci_next    = ci_snap ? '0 : ci_sat;
                zr_next    = '0;
                zi_next    = '0;
                zr2_next   = '0;
                zi2_next   = '0;
                it_next    = '0;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                state_next = keep_going ? ST_MXY : ST_DONE;
            end
            ST_MXY:
            begin
                zr_next    = sat32(zr_sum);
                state_next = ST_MRR;
            end
            ST_MRR:
            begin
                zi_next    = sat32(zi_sum);
                it_next    = it_reg + 1'b1;
                state_next = ST_MII;
            end
            ST_MII:
            begin
                zr2_next   = prod[PROD_W-2:0];
                state_next = ST_WII;
            end
            ST_WII:
            begin
                zi2_next   = prod[PROD_W-2:0];
                state_next = ST_TEST;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_col_next   = col_reg;
                    res_row_next   = row_reg;
                    res_int_next   = (it_reg == iter_limit_reg);
                    res_it_next    = it_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            origin_real_reg <= ORIGIN_REAL_RST;
            origin_imag_reg <= ORIGIN_IMAG_RST;
            step_x_reg      <= STEP_X_RST;
            step_y_reg      <= STEP_Y_RST;
            iter_limit_reg  <= ITER_LIMIT_RST;
            esc_limit_reg   <= ESCAPE_LIMIT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_ORIGIN_REAL:  origin_real_reg <= $signed(cfg_data);
                    REG_ORIGIN_IMAG:  origin_imag_reg <= $signed(cfg_data);
                    REG_STEP_X:       step_x_reg      <= cfg_data[STEP_W-1:0];
                    REG_STEP_Y:       step_y_reg      <= cfg_data[STEP_W-1:0];
                    REG_ITER_LIMIT:   iter_limit_reg  <= cfg_data[ITER_W-1:0];
                    REG_ESCAPE_LIMIT: esc_limit_reg   <= cfg_data[ESC_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        row_reg     <= row_next;
        cr_reg      <= cr_next;
        ci_reg      <= ci_next;
        zr_reg      <= zr_next;
        zi_reg      <= zi_next;
        zr2_reg     <= zr2_next;
        zi2_reg     <= zi2_next;
        it_reg      <= it_next;
        res_col_reg <= res_col_next;
        res_row_reg <= res_row_next;
        res_int_reg <= res_int_next;
        res_it_reg  <= res_it_next;
    end

    // Outputs
    assign out_valid  = out_valid_reg;
    assign out_column = res_col_reg;
    assign out_row    = res_row_reg;
    assign interior   = res_int_reg;
    assign iterations = res_it_reg;
    assign shade      = res_int_reg ? SHADE_INTERIOR : SHADE_EXTERIOR;

endmodule

`default_nettype wire

// ===== rtl/mep_checker.sv =====
// ----------------------------------------------------------------------------
// mep_checker
// Port-level checks for the Mandelbrot escape pixel evaluator, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mandelbrot_escape_pixel_defines.svh"

module mep_checker
    import mep_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [COORD_W-1:0] out_column,
    input wire logic [COORD_W-1:0] out_row,
    input wire logic               interior,
    input wire logic [ITER_W-1:0]  iterations,
    input wire logic [SHADE_W-1:0] shade
);

    // a taken request keeps the evaluator busy next cycle
    `MEP_ASSERT_NXT(a_busy_after_request, in_valid && in_ready, !in_ready)

    // shade follows the interior flag
    `MEP_ASSERT_IMP(a_shade_matches, out_valid, shade == (interior ? SHADE_INTERIOR : SHADE_EXTERIOR))

    // a result never appears right on the cycle after a request is taken
    `MEP_ASSERT_IMP(a_no_instant_result, $rose(out_valid), !$past(in_valid && in_ready))

    // a stalled result holds its payload
    `MEP_ASSERT_NXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(out_column) && $stable(out_row) && $stable(iterations) && $stable(interior))

endmodule

bind mandelbrot_escape_pixel mep_checker u_mep_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_column (out_column),
    .out_row    (out_row),
    .interior   (interior),
    .iterations (iterations),
    .shade      (shade)
);

`default_nettype wire
